@@ design/qbz_pkg.sv @@
// Shared types and constants for the quadratic Bezier sample projector.
// No dependencies; every other design file imports this package.
package qbz_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_POINT_A  = 3'd0;
  localparam logic [2:0] REG_POINT_B  = 3'd1;
  localparam logic [2:0] REG_POINT_C  = 3'd2;
  localparam logic [2:0] REG_ROW_X    = 3'd3;
  localparam logic [2:0] REG_ROW_Y    = 3'd4;
  localparam logic [2:0] REG_ROW_Z    = 3'd5;
  localparam logic [2:0] REG_VIEWPORT = 3'd6;

  // Quotient bits produced by the divider, one per stage.
  localparam int DIV_N = 48;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } qbz_pt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [47:0] num;
  } qbz_div_lane_t;

  typedef struct packed {
    qbz_div_lane_t lx;
    qbz_div_lane_t ly;
    logic [31:0]   den;
    logic          neg_x;
    logic          neg_y;
    logic          zero;
  } qbz_div_t;

endpackage

@@ design/qbz_curve.sv @@
// Curve stage: clamps the sample index, forms t and runs the two levels of
// linear interpolation. Six register stages. Depends on qbz_pkg.
module qbz_curve import qbz_pkg::*; #(
  parameter int SAMPLES = 100
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [10:0] sample_index,
  input  logic [47:0] point_a,
  input  logic [47:0] point_b,
  input  logic [47:0] point_c,
  output logic        out_valid,
  output qbz_pt_t     p
);

  localparam logic [41:0] RECIP = 42'((64'd1 << 42) / SAMPLES);
  localparam logic [10:0] S11   = 11'(SAMPLES);

  logic [5:0]  vld;
  logic [10:0] k_clamp;
  logic [10:0] k1;
  logic [52:0] kprod;
  logic [16:0] approx;
  logic [27:0] back;
  logic [27:0] resid;
  logic [16:0] t2, t3, t4;

  logic signed [34:0] prod_ab [3];
  logic signed [34:0] prod_bc [3];
  logic signed [15:0] l_ab [3];
  logic signed [15:0] l_bc [3];
  logic signed [34:0] prod2 [3];
  logic signed [15:0] base5 [3];
  logic signed [15:0] pc [3];

  assign k_clamp = (sample_index > S11) ? S11 : sample_index;
  assign approx  = kprod[42:26];
  assign back    = 28'(approx) * 28'(S11);
  assign resid   = {1'b0, k1, 16'b0} - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  // The reciprocal product undershoots by at most one; one compare fixes it.
  always_ff @(posedge clk) begin
    if (en) begin
      k1    <= k_clamp;
      kprod <= 53'(k_clamp) * 53'(RECIP);
      t2    <= (resid >= 28'(S11)) ? approx + 17'd1 : approx;
      t3    <= t2;
      t4    <= t3;
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_coord
    logic signed [15:0] ca, cb, cc;
    logic signed [34:0] sh_ab, sh_bc, sh2;
    assign ca    = point_a[16*i +: 16];
    assign cb    = point_b[16*i +: 16];
    assign cc    = point_c[16*i +: 16];
    assign sh_ab = prod_ab[i] >>> 16;
    assign sh_bc = prod_bc[i] >>> 16;
    assign sh2   = prod2[i] >>> 16;

    always_ff @(posedge clk) begin
      if (en) begin
        prod_ab[i] <= (17'(ca) * -17'sd1 + 17'(cb)) * $signed({1'b0, t2});
        prod_bc[i] <= (17'(cb) * -17'sd1 + 17'(cc)) * $signed({1'b0, t2});
        l_ab[i]    <= ca + sh_ab[15:0];
        l_bc[i]    <= cb + sh_bc[15:0];
        prod2[i]   <= (17'(l_bc[i]) - 17'(l_ab[i])) * $signed({1'b0, t4});
        base5[i]   <= l_ab[i];
        pc[i]      <= base5[i] + sh2[15:0];
      end
    end
  end

  assign p.x       = pc[0];
  assign p.y       = pc[1];
  assign p.z       = pc[2];
  assign out_valid = vld[5];

`ifndef SYNTHESIS
  a_t_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> t2 <= 17'd65536)
    else $error("curve parameter above one");
`endif

endmodule

@@ design/qbz_transform.sv @@
// Matrix stage: applies the three matrix rows to the curve point and
// prepares sign and magnitudes for the divider. Depends on qbz_pkg.
module qbz_transform import qbz_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  qbz_pt_t     p,
  input  logic [63:0] row_x,
  input  logic [63:0] row_y,
  input  logic [63:0] row_z,
  output logic        out_valid,
  output qbz_div_t    d
);

  logic [2:0] vld;
  logic signed [31:0] mp [3][3];
  logic signed [33:0] acc [3];
  logic signed [33:0] mag [3];
  logic [63:0] rows [3];
  logic signed [15:0] pv [3];

  assign rows[0] = row_x;
  assign rows[1] = row_y;
  assign rows[2] = row_z;
  assign pv[0]   = p.x;
  assign pv[1]   = p.y;
  assign pv[2]   = p.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_valid};
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    logic signed [15:0] m3;
    assign m3     = rows[r][63:48];
    assign mag[r] = acc[r][33] ? -acc[r] : acc[r];
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          mp[r][c] <= $signed(rows[r][16*c +: 16]) * pv[c];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        acc[r] <= 34'(mp[r][0]) + 34'(mp[r][1]) + 34'(mp[r][2]) + (34'(m3) <<< 8);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d.lx.rem <= '0;
      d.ly.rem <= '0;
      d.lx.num <= {mag[0][31:0], 16'b0};
      d.ly.num <= {mag[1][31:0], 16'b0};
      d.den    <= mag[2][31:0];
      d.neg_x  <= acc[0][33] ^ acc[2][33];
      d.neg_y  <= acc[1][33] ^ acc[2][33];
      d.zero   <= (acc[2] == '0);
    end
  end

  assign out_valid = vld[2];

endmodule

@@ design/qbz_div_stage.sv @@
// One step of the pipelined restoring divider: one quotient bit for each
// of the x and y lanes, sharing the divisor. Depends on qbz_pkg.
module qbz_div_stage import qbz_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  qbz_div_t d_in,
  output logic     out_valid,
  output qbz_div_t d_out
);

  function automatic qbz_div_lane_t step(qbz_div_lane_t l, logic [31:0] den);
    logic [32:0]   sh;
    logic [32:0]   diff;
    logic          ge;
    qbz_div_lane_t r;
    sh    = {l.rem, l.num[47]};
    ge    = (sh >= {1'b0, den});
    diff  = sh - {1'b0, den};
    r.rem = ge ? diff[31:0] : sh[31:0];
    r.num = {l.num[46:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.lx    <= step(d_in.lx, d_in.den);
      d_out.ly    <= step(d_in.ly, d_in.den);
      d_out.den   <= d_in.den;
      d_out.neg_x <= d_in.neg_x;
      d_out.neg_y <= d_in.neg_y;
      d_out.zero  <= d_in.zero;
    end
  end

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && !d_out.zero |-> d_out.lx.rem < d_out.den && d_out.ly.rem < d_out.den)
    else $error("divider remainder not below divisor");
`endif

endmodule

@@ design/qbz_screen.sv @@
// Screen mapping: signs the quotients, applies the viewport scale and
// offset, saturates and holds the output word. Depends on qbz_pkg.
module qbz_screen import qbz_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  qbz_div_t           d,
  input  logic [63:0]        viewport_terms,
  output logic               out_valid,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               depth_zero
);

  localparam logic signed [66:0] MAXV = 67'sd2147483647;
  localparam logic signed [66:0] MINV = -67'sd2147483648;

  logic [1:0] vld;
  logic signed [49:0] qx, qy;
  logic signed [65:0] px, py;
  logic z1, z2;

  function automatic logic signed [49:0] shifted_q(logic [47:0] num, logic neg);
    logic signed [49:0] m;
    m = $signed({2'b0, num});
    return (neg ? -m : m) + 50'sd65536;
  endfunction

  function automatic logic signed [31:0] finish(logic signed [65:0] prod,
                                                logic signed [15:0] off);
    logic signed [66:0] v;
    v = 67'(prod >>> 17) + 67'(off);
    if (v > MAXV) begin
      return 32'sh7fffffff;
    end else if (v < MINV) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[0], in_valid};
      out_valid <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qx <= shifted_q(d.lx.num, d.neg_x);
      qy <= shifted_q(d.ly.num, d.neg_y);
      z1 <= d.zero;
      px <= qx * $signed(viewport_terms[15:0]);
      py <= qy * $signed(viewport_terms[47:32]);
      z2 <= z1;
      screen_x   <= z2 ? '0 : finish(px, $signed(viewport_terms[31:16]));
      screen_y   <= z2 ? '0 : finish(py, $signed(viewport_terms[63:48]));
      depth_zero <= z2;
    end
  end

endmodule

@@ design/quadratic_bezier_project.sv @@
// Top level of the quadratic Bezier sample projector: configuration
// registers, pipeline stall control and the stage chain. Uses qbz_pkg.
//
// Usage: write the control points, matrix rows and viewport terms through
// the configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// while no samples are in flight; indexes beyond the list are ignored.
// Samples enter on in_valid/in_ready with sample_index; each produces one
// word on out_valid/out_ready carrying screen_x, screen_y and depth_zero.
// Samples pass through the curve, the matrix, the 48-stage divider (one
// quotient bit per stage) and the screen mapping. Throughput is one sample
// per cycle while the receiver takes the words; every stage moves together
// under a single enable, so the divider chain sets the depth, not the rate.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated. Reset clears all valid
// bits and every configuration register to zero.
module quadratic_bezier_project import qbz_pkg::*; #(
  parameter int SAMPLES = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [10:0]        sample_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] screen_x,
  output logic signed [31:0] screen_y,
  output logic               depth_zero,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [47:0] point_a, point_b, point_c;
  logic [63:0] row_x, row_y, row_z, viewport_terms;
  logic        en;
  logic        curve_valid, xf_valid;
  qbz_pt_t     curve_p;
  qbz_div_t    div_pipe [DIV_N+1];
  logic [DIV_N:0] div_valid;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_a        <= '0;
      point_b        <= '0;
      point_c        <= '0;
      row_x          <= '0;
      row_y          <= '0;
      row_z          <= '0;
      viewport_terms <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POINT_A:  point_a        <= cfg_data[47:0];
        REG_POINT_B:  point_b        <= cfg_data[47:0];
        REG_POINT_C:  point_c        <= cfg_data[47:0];
        REG_ROW_X:    row_x          <= cfg_data;
        REG_ROW_Y:    row_y          <= cfg_data;
        REG_ROW_Z:    row_z          <= cfg_data;
        REG_VIEWPORT: viewport_terms <= cfg_data;
        default: ;
      endcase
    end
  end

  qbz_curve #(.SAMPLES(SAMPLES)) u_curve (
    .clk, .rst, .en,
    .in_valid     (in_valid && in_ready),
    .sample_index,
    .point_a, .point_b, .point_c,
    .out_valid    (curve_valid),
    .p            (curve_p)
  );

  qbz_transform u_xf (
    .clk, .rst, .en,
    .in_valid  (curve_valid),
    .p         (curve_p),
    .row_x, .row_y, .row_z,
    .out_valid (div_valid[0]),
    .d         (div_pipe[0])
  );

  assign xf_valid = div_valid[0];

  for (genvar s = 0; s < DIV_N; s++) begin : g_div
    qbz_div_stage u_stage (
      .clk, .rst, .en,
      .in_valid  (div_valid[s]),
      .d_in      (div_pipe[s]),
      .out_valid (div_valid[s+1]),
      .d_out     (div_pipe[s+1])
    );
  end

  qbz_screen u_screen (
    .clk, .rst, .en,
    .in_valid  (div_valid[DIV_N]),
    .d         (div_pipe[DIV_N]),
    .viewport_terms,
    .out_valid,
    .screen_x, .screen_y, .depth_zero
  );

`ifndef SYNTHESIS
  a_zero_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_zero |-> screen_x == 0 && screen_y == 0)
    else $error("zero depth word with nonzero coordinates");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !xf_valid)
    else $error("pipeline holds a word after reset");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    xf_valid && !en |=> xf_valid)
    else $error("divider input lost during a stall");
`endif

endmodule

@@ verif/qbz_checker.sv @@
// Scoreboard for the quadratic Bezier sample projector: keeps its own register copy,
// computes each screen point and checks the words returned. Depends on qbz_pkg.
module qbz_checker import qbz_pkg::*; #(
  parameter int SAMPLES = 100
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [10:0]        sample_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] screen_x,
  input  logic signed [31:0] screen_y,
  input  logic               depth_zero,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               dz;
  } screen_pt_t;

  screen_pt_t  expected_pts[$];
  logic [47:0] pa, pb, pc;
  logic [63:0] rx, ry, rz, vp;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic longint sfield(logic [63:0] w, int slot);
    logic signed [15:0] f;
    f = w[slot*16 +: 16];
    return longint'(f);
  endfunction

  // Arithmetic shift on a signed value rounds towards minus infinity.
  function automatic longint lerp(longint a, longint b, longint t16);
    return a + ((b - a) * t16 >>> 16);
  endfunction

  function automatic longint apply_row(logic [63:0] r, longint p[3]);
    return sfield(r, 0) * p[0] + sfield(r, 1) * p[1] + sfield(r, 2) * p[2] +
           sfield(r, 3) * 256;
  endfunction

  function automatic logic signed [31:0] to_screen(longint q, longint sc, longint off);
    longint v;
    v = ((q + 65536) * sc >>> 17) + off;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic screen_pt_t project_sample(logic [10:0] idx);
    screen_pt_t r;
    longint k, t16, px, py, pz;
    longint p[3];
    k = idx;
    if (k > SAMPLES) k = SAMPLES;
    t16 = (k * 65536) / SAMPLES;
    for (int i = 0; i < 3; i++) begin
      p[i] = lerp(lerp(sfield(pa, i), sfield(pb, i), t16),
                  lerp(sfield(pb, i), sfield(pc, i), t16), t16);
    end
    px = apply_row(rx, p);
    py = apply_row(ry, p);
    pz = apply_row(rz, p);
    if (pz == 0) begin
      r.sx = 0;
      r.sy = 0;
      r.dz = 1'b1;
    end else begin
      // Signed division truncates towards zero, as the quotient requires.
      r.sx = to_screen((px * 65536) / pz, sfield(vp, 0), sfield(vp, 1));
      r.sy = to_screen((py * 65536) / pz, sfield(vp, 2), sfield(vp, 3));
      r.dz = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    screen_pt_t e;
    if (rst) begin
      pa <= '0; pb <= '0; pc <= '0;
      rx <= '0; ry <= '0; rz <= '0; vp <= '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pts.size() == 0) begin
          report_mismatch("words outstanding", 1, 0);
        end else begin
          e = expected_pts.pop_front();
          if (screen_x !== e.sx) report_mismatch("screen_x", screen_x, e.sx);
          if (screen_y !== e.sy) report_mismatch("screen_y", screen_y, e.sy);
          if (depth_zero !== e.dz) report_mismatch("depth_zero", depth_zero, e.dz);
        end
      end
      if (in_valid && in_ready) expected_pts.push_back(project_sample(sample_index));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POINT_A:  pa <= cfg_data[47:0];
          REG_POINT_B:  pb <= cfg_data[47:0];
          REG_POINT_C:  pc <= cfg_data[47:0];
          REG_ROW_X:    rx <= cfg_data;
          REG_ROW_Y:    ry <= cfg_data;
          REG_ROW_Z:    rz <= cfg_data;
          REG_VIEWPORT: vp <= cfg_data;
          default: ;
        endcase
      end
      pending <= expected_pts.size();
    end
  end
endmodule

@@ verif/quadratic_bezier_project_tb.sv @@
// Stimulus and verdict for the quadratic Bezier sample projector.
// Depends on qbz_pkg, quadratic_bezier_project and qbz_checker.
module quadratic_bezier_project_tb import qbz_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [10:0]        sample_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] screen_x, screen_y;
  logic               depth_zero;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               quiet = 1'b0;
  int                 errors, pending, stall_left = 0;

  quadratic_bezier_project u_top (.*);

  qbz_checker u_chk (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver back-pressure in short bursts.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                             logic [63:0] x, logic [63:0] y, logic [63:0] z,
                             logic [63:0] v);
    // Stop sending so that the pipeline can drain before the registers change.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    write_reg(REG_POINT_A, {16'($urandom), a});
    write_reg(REG_POINT_B, b);
    write_reg(REG_POINT_C, c);
    write_reg(REG_ROW_X, x);
    write_reg(REG_ROW_Y, y);
    write_reg(REG_ROW_Z, z);
    write_reg(REG_VIEWPORT, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [10:0] k);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_index <= k;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly modest Q8.8 values, with the extremes now and then.
  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  function automatic logic [47:0] pick_pt();
    return {pick16(), pick16(), pick16()};
  endfunction

  function automatic logic [63:0] pick_word();
    return {pick16(), pick16(), pick16(), pick16()};
  endfunction

  function automatic logic [10:0] pick_index();
    if ($urandom_range(0, 9) == 0) return 11'($urandom);
    return 11'($urandom_range(0, 110));
  endfunction

  initial begin
    logic [10:0] edges[13] = '{11'd0, 11'd1, 11'd2, 11'd50, 11'd99, 11'd100, 11'd101,
                               11'd512, 11'd1024, 11'd1365, 11'd2047, 11'h2AA, 11'h555};
    logic [63:0] z_row;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers still at reset: every sample has zero depth.
    send_sample(11'd0);
    send_sample(11'd2047);

    // Unit matrix with depth 1.0 and unit viewport; index 7 must be ignored.
    load_config(48'h0000_0200_FE00, 48'h0100_FD00_0300, 48'h0080_0400_0100,
                64'h0000_0000_0000_0100, 64'h0000_0000_0100_0000,
                64'h0100_0000_0000_0000, 64'h0000_0100_0000_0100);
    write_reg(3'd7, '1);
    cfg_valid <= 1'b0;
    foreach (edges[i]) send_sample(edges[i]);

    // Extremes in most fields, then a case where the depth row is all zero.
    load_config(48'h7FFF_8000_7FFF, 48'h8000_7FFF_8000, 48'h7FFF_7FFF_8000,
                64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
                64'h0001_0000_0000_0000, 64'h8000_7FFF_7FFF_8000);
    for (int i = 0; i < 5; i++) send_sample(edges[i * 2]);
    load_config(48'h0000_0000_0000, 48'h0000_0000_0000, 48'h0000_0000_0000,
                64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000,
                64'h0000_0000_0000_0000, 64'h7FFF_8000_8000_7FFF);
    send_sample(11'd100);

    for (int ph = 0; ph < 8; ph++) begin
      z_row = pick_word();
      if (z_row[63:48] == 16'h0000) z_row[63:48] = 16'h0100;
      if (ph % 2 == 0) z_row = {$urandom, $urandom};
      load_config(pick_pt(), pick_pt(), pick_pt(), pick_word(), pick_word(), z_row,
                  pick_word());
      for (int i = 0; i < 119; i++) begin
        if (ph == 7 && i == 20) quiet <= 1'b1;
        // Hold the sender once until the pipeline has drained completely.
        if (ph == 1 && i == 60) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        send_sample(pick_index());
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

@@ files.f @@
design/qbz_pkg.sv
design/qbz_curve.sv
design/qbz_transform.sv
design/qbz_div_stage.sv
design/qbz_screen.sv
design/quadratic_bezier_project.sv
verif/qbz_checker.sv
verif/quadratic_bezier_project_tb.sv
